### hw/rtl/ogs_pkg.sv
// shared types, constants and the 5x8 font rom for the glyph streamer
`default_nettype none

package ogs_pkg;

    localparam int DISPLAY_WIDTH_DEF = 128;
    localparam int QUEUE_DEPTH       = 2;

    // byte slots within one character run
    localparam logic [3:0] SLOT_COL_CMD   = 4'd0;
    localparam logic [3:0] SLOT_COL_START = 4'd1;
    localparam logic [3:0] SLOT_COL_END   = 4'd2;
    localparam logic [3:0] SLOT_PAGE_CMD  = 4'd3;
    localparam logic [3:0] SLOT_PAGE      = 4'd4;
    localparam logic [3:0] SLOT_PAGE_END  = 4'd5;
    localparam logic [3:0] SLOT_GLYPH0    = 4'd6;
    localparam logic [3:0] SLOT_GLYPH1    = 4'd7;
    localparam logic [3:0] SLOT_GLYPH2    = 4'd8;
    localparam logic [3:0] SLOT_GLYPH3    = 4'd9;
    localparam logic [3:0] SLOT_GLYPH4    = 4'd10;
    localparam logic [3:0] SLOT_LAST      = 4'd13;

    // display controller commands
    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_COL_END   = 8'h7F;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CMD_PAGE_END  = 8'h07;

    localparam logic [7:0] GLYPH_FIRST = 8'h20;
    localparam logic [7:0] GLYPH_LAST  = 8'h7E;

    typedef struct packed {
        logic [2:0] page;
        logic [7:0] column;
        logic [6:0] glyph;
    } t_job;

    // five leading columns of a glyph, first column in the top byte
    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] row;
        unique case (idx)
            7'd0:  row = 40'h0000000000;
            7'd1:  row = 40'h00005F0000;
            7'd2:  row = 40'h0007000700;
            7'd3:  row = 40'h147F147F14;
            7'd4:  row = 40'h242A7F2A12;
            7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250;
            7'd7:  row = 40'h0005030000;
            7'd8:  row = 40'h001C224100;
            7'd9:  row = 40'h0041221C00;
            7'd10: row = 40'h082A1C2A08;
            7'd11: row = 40'h08083E0808;
            7'd12: row = 40'h0050300000;
            7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0060600000;
            7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3E5149453E;
            7'd17: row = 40'h00427F4000;
            7'd18: row = 40'h4261514946;
            7'd19: row = 40'h2141454B31;
            7'd20: row = 40'h1814127F10;
            7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3C4A494930;
            7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936;
            7'd25: row = 40'h064949291E;
            7'd26: row = 40'h0036360000;
            7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0008142241;
            7'd29: row = 40'h1414141414;
            7'd30: row = 40'h4122140800;
            7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413E;
            7'd33: row = 40'h7E1111117E;
            7'd34: row = 40'h7F49494936;
            7'd35: row = 40'h3E41414122;
            7'd36: row = 40'h7F4141221C;
            7'd37: row = 40'h7F49494941;
            7'd38: row = 40'h7F09090101;
            7'd39: row = 40'h3E41415132;
            7'd40: row = 40'h7F0808087F;
            7'd41: row = 40'h00417F4100;
            7'd42: row = 40'h2040413F01;
            7'd43: row = 40'h7F08142241;
            7'd44: row = 40'h7F40404040;
            7'd45: row = 40'h7F0204027F;
            7'd46: row = 40'h7F0408107F;
            7'd47: row = 40'h3E4141413E;
            7'd48: row = 40'h7F09090906;
            7'd49: row = 40'h3E4151215E;
            7'd50: row = 40'h7F09192946;
            7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017F0101;
            7'd53: row = 40'h3F4040403F;
            7'd54: row = 40'h1F2040201F;
            7'd55: row = 40'h7F2018207F;
            7'd56: row = 40'h6314081463;
            7'd57: row = 40'h0304780403;
            7'd58: row = 40'h6151494543;
            7'd59: row = 40'h00007F4141;
            7'd60: row = 40'h0204081020;
            7'd61: row = 40'h41417F0000;
            7'd62: row = 40'h0402010204;
            7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0001020400;
            7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7F48444438;
            7'd67: row = 40'h3844444420;
            7'd68: row = 40'h384444487F;
            7'd69: row = 40'h3854545418;
            7'd70: row = 40'h087E090102;
            7'd71: row = 40'h081454543C;
            7'd72: row = 40'h7F08040478;
            7'd73: row = 40'h00447D4000;
            7'd74: row = 40'h2040443D00;
            7'd75: row = 40'h007F102844;
            7'd76: row = 40'h00417F4000;
            7'd77: row = 40'h7C04180478;
            7'd78: row = 40'h7C08040478;
            7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7C14141408;
            7'd81: row = 40'h081414187C;
            7'd82: row = 40'h7C08040408;
            7'd83: row = 40'h4854545420;
            7'd84: row = 40'h043F444020;
            7'd85: row = 40'h3C4040207C;
            7'd86: row = 40'h1C2040201C;
            7'd87: row = 40'h3C4030403C;
            7'd88: row = 40'h4428102844;
            7'd89: row = 40'h0C5050503C;
            7'd90: row = 40'h4464544C44;
            7'd91: row = 40'h0008364100;
            7'd92: row = 40'h00007F0000;
            7'd93: row = 40'h0041360800;
            7'd94: row = 40'h0804081008;
            default: row = 40'h0000000000;
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ogs_front.sv
// front end: tracks page and column, drops characters past the edge, queues jobs
`default_nettype none

module ogs_front #(
    parameter int DISPLAY_WIDTH = ogs_pkg::DISPLAY_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_start_req,
    input  wire logic [2:0]    i_page,
    input  wire logic [6:0]    i_column,
    input  wire logic [7:0]    i_character,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ogs_pkg::t_job      o_job
);

    logic [2:0] r_page;
    logic [7:0] r_column;
    logic [2:0] n_page;
    logic [7:0] n_column;
    logic [2:0] eff_page;
    logic [7:0] eff_column;
    logic [8:0] col_end;
    logic       fits;
    logic       accept;
    logic       printable;
    logic [6:0] glyph_ofs;

    assign o_ready    = !i_q_full;
    assign accept     = i_valid && o_ready;
    assign eff_page   = i_start_req ? i_page : r_page;
    assign eff_column = i_start_req ? {1'b0, i_column} : r_column;
    assign col_end    = {1'b0, eff_column} + 9'd8;
    assign fits       = (col_end <= 9'(DISPLAY_WIDTH));
    assign o_push     = accept && fits;

    // non printable codes draw as a space
    assign printable = (i_character >= ogs_pkg::GLYPH_FIRST) &&
                       (i_character <= ogs_pkg::GLYPH_LAST);
    assign glyph_ofs = 7'(i_character - ogs_pkg::GLYPH_FIRST);

    always_comb begin
        o_job.page   = eff_page;
        o_job.column = eff_column;
        o_job.glyph  = printable ? glyph_ofs : 7'd0;
    end

    always_comb begin
        n_page   = r_page;
        n_column = r_column;
        if (accept) begin
            n_page   = eff_page;
            // column saturates once a character no longer fits
            n_column = fits ? col_end[7:0] : eff_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page   <= 3'd0;
            r_column <= 8'd0;
        end else begin
            r_page   <= n_page;
            r_column <= n_column;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ogs_queue.sv
// short job queue between front and back
`default_nettype none

module ogs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ogs_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output ogs_pkg::t_job      o_job
);

    localparam int PtrW = $clog2(ogs_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(ogs_pkg::QUEUE_DEPTH + 1);

    ogs_pkg::t_job r_mem [ogs_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(ogs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(ogs_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = do_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ogs_back.sv
// back end: walks the 14 byte run of the head job into the output register
`default_nettype none

module ogs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire ogs_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_is_data,
    output logic               o_last
);

    logic [3:0]  r_slot;
    logic [3:0]  n_slot;
    logic        r_valid;
    logic        n_valid;
    logic [7:0]  r_byte;
    logic        r_is_data;
    logic        r_last;
    logic [7:0]  byte_sel;
    logic [39:0] glyph_row;
    logic        load;
    logic        end_of_run;

    assign glyph_row  = ogs_pkg::font_row(i_job.glyph);
    assign load       = i_q_valid && (!r_valid || i_ready);
    assign end_of_run = (r_slot == ogs_pkg::SLOT_LAST);
    assign o_pop      = load && end_of_run;

    always_comb begin
        unique case (r_slot)
            ogs_pkg::SLOT_COL_CMD:   byte_sel = ogs_pkg::CMD_COL_ADDR;
            ogs_pkg::SLOT_COL_START: byte_sel = i_job.column;
            ogs_pkg::SLOT_COL_END:   byte_sel = ogs_pkg::CMD_COL_END;
            ogs_pkg::SLOT_PAGE_CMD:  byte_sel = ogs_pkg::CMD_PAGE_ADDR;
            ogs_pkg::SLOT_PAGE:      byte_sel = {5'd0, i_job.page};
            ogs_pkg::SLOT_PAGE_END:  byte_sel = ogs_pkg::CMD_PAGE_END;
            ogs_pkg::SLOT_GLYPH0:    byte_sel = glyph_row[39:32];
            ogs_pkg::SLOT_GLYPH1:    byte_sel = glyph_row[31:24];
            ogs_pkg::SLOT_GLYPH2:    byte_sel = glyph_row[23:16];
            ogs_pkg::SLOT_GLYPH3:    byte_sel = glyph_row[15:8];
            ogs_pkg::SLOT_GLYPH4:    byte_sel = glyph_row[7:0];
            default:                 byte_sel = 8'd0;
        endcase
    end

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_slot  = end_of_run ? ogs_pkg::SLOT_COL_CMD : r_slot + 4'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= ogs_pkg::SLOT_COL_CMD;
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= byte_sel;
            r_is_data <= (r_slot >= ogs_pkg::SLOT_GLYPH0);
            r_last    <= end_of_run;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_is_data  = r_is_data;
    assign o_last     = r_last;

endmodule

`default_nettype wire

### hw/rtl/oled_text_glyph_streamer_top.sv
// top level of the page mode oled text glyph streamer
// usage:
//   input channel (i_valid / o_ready) takes one character word; i_start_req
//   loads page and start column, otherwise the tracked column is used
//   output channel (o_valid / i_ready) gives one display byte per word with
//   a data/command mark and a last flag on the 14th byte of a run
// a drawn character is written into the queue when it is accepted; its first
//   byte is loaded from the queue head into the output register
// the back end emits one byte per cycle while the receiver is ready, so the run
//   length of the back end sets the character rate
// a character that would pass the right edge produces nothing but is still
//   accepted; the column stays where it was
// the two entry job queue lets the front take the next character while the
//   back end is still streaming the current one
// receiver stall: the output register holds its byte, the back end pauses,
//   and the front stops once the queue is full
// reset: page and column return to zero, queue and output register empty
`default_nettype none

module oled_text_glyph_streamer_top #(
    parameter int DISPLAY_WIDTH = ogs_pkg::DISPLAY_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_start_req,
    input  wire logic [2:0] i_page,
    input  wire logic [6:0] i_column,
    input  wire logic [7:0] i_character,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_is_data,
    output logic            o_last
);

    // front to queue
    logic          q_full;
    logic          q_push;
    ogs_pkg::t_job push_job;

    // queue to back
    logic          q_valid;
    logic          q_pop;
    ogs_pkg::t_job head_job;

    // classify each character word and track the cursor
    ogs_front #(
        .DISPLAY_WIDTH(DISPLAY_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .i_page      (i_page),
        .i_column    (i_column),
        .i_character (i_character),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    // decouples the front from the back end that streams each run
    ogs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // window commands then glyph columns, one byte per cycle while the receiver is ready
    ogs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_is_data  (o_is_data),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

### tb/sv/oled_text_glyph_streamer_top_tb.sv
// testbench for the oled text glyph streamer: directed and random characters
`timescale 1ns / 100ps

module oled_text_glyph_streamer_top_tb;

    // one byte of a run as the display controller sees it
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       last;
    } t_disp_byte;

    // one row of the directed table; typed rows carry their own expected run
    typedef struct packed {
        logic       start;
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] code;
        logic       typed;
        logic       t_drawn;
        logic [7:0] t_column;
        logic [2:0] t_page;
        logic [39:0] t_glyph;
    } t_char_case;

    localparam int  DISPLAY_WIDTH = ogs_pkg::DISPLAY_WIDTH_DEF;
    localparam int  RUN_BYTES     = int'(ogs_pkg::SLOT_LAST) + 1;
    localparam int  GLYPH_STEP    = 8;
    localparam int  RANDOM_ITEMS  = 340;
    localparam int  DRAIN_CYCLES  = 16;
    localparam int  CYCLE_LIMIT   = 1_500_000;
    localparam logic DC_CMD       = 1'b0;
    localparam logic DC_DATA      = 1'b1;

    // receiver stall styles
    localparam logic [1:0] RX_ALWAYS  = 2'd0;
    localparam logic [1:0] RX_PATTERN = 2'd1;
    localparam logic [1:0] RX_RANDOM  = 2'd2;
    localparam logic [1:0] RX_LONG    = 2'd3;

    // five leading columns of each printable glyph, first column in the top byte
    logic [39:0] glyph_cols [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
        40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
    };

    // dut inputs, all known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_start_req = 1'b0;
    logic [2:0] i_page      = '0;
    logic [6:0] i_column    = '0;
    logic [7:0] i_character = '0;
    logic       i_ready     = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_data;
    logic       o_last;

    // predicted cursor of the block
    logic [2:0] cursor_page = '0;
    logic [7:0] cursor_column = '0;

    t_disp_byte run_bytes [RUN_BYTES];  // last run built
    t_disp_byte pending_display_bytes [$];
    t_char_case directed_chars [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    // receiver stall state
    logic [1:0]  rx_style   = RX_ALWAYS;
    logic [15:0] rx_pattern = '1;
    int          rx_hold    = 0;

    always #2 i_clk = ~i_clk;

    oled_text_glyph_streamer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .i_page      (i_page),
        .i_column    (i_column),
        .i_character (i_character),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // fill run_bytes: six window commands, then eight glyph columns
    function automatic void build_run(input logic [7:0] column, input logic [2:0] page,
                                      input logic [39:0] cols);
        for (int k = 0; k < RUN_BYTES; k++) begin
            run_bytes[k].value   = 8'h00;
            run_bytes[k].is_data = (k >= int'(ogs_pkg::SLOT_GLYPH0)) ? DC_DATA : DC_CMD;
            run_bytes[k].last    = (k == int'(ogs_pkg::SLOT_LAST));
        end
        run_bytes[ogs_pkg::SLOT_COL_CMD].value   = ogs_pkg::CMD_COL_ADDR;
        run_bytes[ogs_pkg::SLOT_COL_START].value = column;
        run_bytes[ogs_pkg::SLOT_COL_END].value   = ogs_pkg::CMD_COL_END;
        run_bytes[ogs_pkg::SLOT_PAGE_CMD].value  = ogs_pkg::CMD_PAGE_ADDR;
        run_bytes[ogs_pkg::SLOT_PAGE].value      = {5'b0, page};
        run_bytes[ogs_pkg::SLOT_PAGE_END].value  = ogs_pkg::CMD_PAGE_END;
        // glyph columns five to seven stay zero
        for (int k = 0; k < 5; k++)
            run_bytes[int'(ogs_pkg::SLOT_GLYPH0) + k].value = cols[39 - 8 * k -: 8];
    endfunction

    // advance the cursor for one character and build its run; returns bytes produced
    function automatic int render_char(input logic start, input logic [2:0] page,
                                       input logic [6:0] column, input logic [7:0] code);
        logic [7:0] glyph;
        if (start) begin
            cursor_page   = page;
            cursor_column = {1'b0, column};
        end
        // past the right edge: nothing drawn, cursor frozen
        if (int'(cursor_column) + GLYPH_STEP > DISPLAY_WIDTH)
            return 0;
        // anything outside the printable range draws as a space
        glyph = (code < ogs_pkg::GLYPH_FIRST || code > ogs_pkg::GLYPH_LAST) ?
                ogs_pkg::GLYPH_FIRST : code;
        build_run(cursor_column, cursor_page, glyph_cols[glyph - ogs_pkg::GLYPH_FIRST]);
        cursor_column = 8'(int'(cursor_column) + GLYPH_STEP);
        return RUN_BYTES;
    endfunction

    task automatic queue_run(input int count);
        for (int k = 0; k < count; k++)
            pending_display_bytes.push_back(run_bytes[k]);
    endtask

    // present one word and hold it until the handshake
    task automatic send_char(input logic start, input logic [2:0] page,
                             input logic [6:0] column, input logic [7:0] code);
        i_valid     <= 1'b1;
        i_start_req <= start;
        i_page      <= page;
        i_column    <= column;
        i_character <= code;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // bursts of random length, mostly with a gap after them, now and then a long run
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 20);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic draw_char(input logic start, input logic [2:0] page,
                             input logic [6:0] column, input logic [7:0] code,
                             output int count);
        send_char(start, page, column, code);
        count = render_char(start, page, column, code);
        queue_run(count);
        pace_sender();
    endtask

    // mostly printable text, some arbitrary codes
    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(int'(ogs_pkg::GLYPH_FIRST), int'(ogs_pkg::GLYPH_LAST)));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_case(input logic start, input logic [2:0] page,
                                     input logic [6:0] column, input logic [7:0] code,
                                     input logic typed, input logic t_drawn,
                                     input logic [7:0] t_column, input logic [2:0] t_page,
                                     input logic [39:0] t_glyph);
        directed_chars.push_back({start, page, column, code, typed, t_drawn,
                                  t_column, t_page, t_glyph});
    endfunction

    // receiver: stall style and pattern are redrawn at random
    always @(posedge i_clk) begin
        if (cycle_count % 256 == 0) begin
            rx_style   <= 2'($urandom_range(0, 3));
            rx_pattern <= 16'($urandom);
        end
        case (rx_style)
            RX_ALWAYS: begin
                i_ready <= 1'b1;
            end
            RX_PATTERN: begin
                i_ready <= rx_pattern[cycle_count % 16];
            end
            RX_RANDOM: begin
                i_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                // occasional long stall
                if (rx_hold > 0) begin
                    rx_hold <= rx_hold - 1;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_hold <= $urandom_range(1, 40);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // compare every accepted byte with the oldest prediction
    always @(posedge i_clk) begin : check_bytes
        t_disp_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_display_bytes.size() == 0) begin
                report_mismatch("byte with none expected", o_out_byte, 0);
            end else begin
                want = pending_display_bytes.pop_front();
                if (o_out_byte !== want.value)
                    report_mismatch("out_byte", o_out_byte, want.value);
                if (o_is_data !== want.is_data)
                    report_mismatch("is_data", o_is_data, want.is_data);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        t_char_case row;
        int count;
        int sent_random;
        int length;
        logic [2:0] page;
        logic [6:0] column;

        // directed table: start, page, column, code, typed, drawn, column, page, glyph
        // after reset the cursor sits at page 0 column 0
        add_case(1'b0, 3'd0, 7'd0,   8'h41, 1'b1, 1'b1, 8'd0,   3'd0, 40'h7E1111117E);
        // no start: page and column fields ignored; control code draws a space
        add_case(1'b0, 3'd7, 7'd127, 8'h00, 1'b1, 1'b1, 8'd8,   3'd0, 40'h0);
        // start past the right edge: dropped, and so is the rest of the string
        add_case(1'b1, 3'd7, 7'd127, 8'h41, 1'b1, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h20, 1'b1, 1'b0, 8'd0,   3'd0, 40'h0);
        // last column that still fits, top code draws a space
        add_case(1'b1, 3'd7, 7'd120, 8'hFF, 1'b1, 1'b1, 8'd120, 3'd7, 40'h0);
        // cursor now at the edge, next one dropped
        add_case(1'b0, 3'd0, 7'd0,   8'h7E, 1'b1, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b1, 3'd0, 7'd0,   8'h7F, 1'b1, 1'b1, 8'd0,   3'd0, 40'h0);
        add_case(1'b1, 3'd5, 7'd121, 8'h21, 1'b1, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b1, 3'd0, 7'd0,   8'h20, 1'b1, 1'b1, 8'd0,   3'd0, 40'h0);
        add_case(1'b1, 3'd2, 7'd0,   8'h21, 1'b1, 1'b1, 8'd0,   3'd2, 40'h00005F0000);
        add_case(1'b0, 3'd0, 7'd0,   8'h1F, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        // unaligned start column, then a string through the font
        add_case(1'b1, 3'd3, 7'd1,   8'h7E, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h30, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h39, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h5A, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h61, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h7A, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h7B, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h7D, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h80, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b0, 3'd0, 7'd0,   8'h55, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b1, 3'd4, 7'd85,  8'h2A, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);
        add_case(1'b1, 3'd6, 7'd42,  8'h40, 1'b0, 1'b0, 8'd0,   3'd0, 40'h0);

        // hold reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_chars[n]) begin
            row = directed_chars[n];
            send_char(row.start, row.page, row.column, row.code);
            // predictor always runs so the cursor stays in step
            count = render_char(row.start, row.page, row.column, row.code);
            if (row.typed) begin
                count = row.t_drawn ? RUN_BYTES : 0;
                if (row.t_drawn)
                    build_run(row.t_column, row.t_page, row.t_glyph);
            end
            queue_run(count);
            pace_sender();
        end

        // random strings, with some lone noise words
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
                draw_char(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), count);
                sent_random++;
            end else begin
                page   = 3'($urandom_range(0, 7));
                column = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 15) * 8)
                                                    : 7'($urandom_range(0, 127));
                length = $urandom_range(1, 16);
                for (int k = 0; k < length; k++) begin
                    // page and column only matter on the first word
                    draw_char(k == 0, (k == 0) ? page : 3'($urandom_range(0, 7)),
                              (k == 0) ? column : 7'($urandom_range(0, 127)),
                              pick_code(), count);
                    sent_random++;
                end
            end
        end
        i_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending_display_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
